// File: hdl/isc_pkg.sv
// Package with the shared constants, types and codes of the interval stabbing counter.
`timescale 1ns / 1ps

package isc_pkg;

  // Store size and the widths that follow from it.
  localparam int MAX_SEGMENTS = 1024;
  localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
  localparam int COUNT_W      = $clog2(MAX_SEGMENTS + 1);

  // Fixed field widths of the channels.
  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 32;
  localparam int HIT_W    = 11;
  localparam int STATUS_W = 2;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2
  } status_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    T_IDLE,
    T_INS_SRCH,
    T_SHIFT,
    T_Q_START,
    T_Q_END,
    T_DONE
  } ctl_state_t;

  // States of the binary search unit.
  typedef enum logic [1:0] {
    SR_IDLE,
    SR_ADDR,
    SR_CMP
  } srch_state_t;

  // Request from the sequencer to the search unit.
  typedef struct packed {
    logic                    start;
    logic                    strict;
    logic [COUNT_W-1:0]      total;
    logic signed [KEY_W-1:0] key;
  } search_req_t;

  // Answer from the search unit.
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] rank;
  } search_rsp_t;

endpackage

// File: hdl/isc_if.sv
// Handshake interfaces for the item and result channels.
`timescale 1ns / 1ps

interface isc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [isc_pkg::FUNC_W-1:0]           func;
  logic signed [isc_pkg::KEY_W-1:0]     seg_start;
  logic signed [isc_pkg::KEY_W-1:0]     seg_end;
  logic signed [isc_pkg::KEY_W-1:0]     point_value;

  modport source (output valid, func, seg_start, seg_end, point_value, input ready);
  modport sink   (input valid, func, seg_start, seg_end, point_value, output ready);
endinterface

interface isc_out_if;
  logic                           valid;
  logic                           ready;
  logic [isc_pkg::HIT_W-1:0]      hit_count;
  logic [isc_pkg::STATUS_W-1:0]   status;

  modport source (output valid, hit_count, status, input ready);
  modport sink   (input valid, hit_count, status, output ready);
endinterface

// File: hdl/isc_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module isc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/isc_search.sv
// Binary search unit that ranks a key against a sorted store; each probe passes an address state and a compare state.
`timescale 1ns / 1ps

module isc_search (
  input  logic                              clk,
  input  logic                              rst,
  input  isc_pkg::search_req_t              req,
  input  logic signed [isc_pkg::KEY_W-1:0]  rd_data,
  output logic [isc_pkg::ADDR_W-1:0]        rd_addr,
  output isc_pkg::search_rsp_t              rsp
);
  import isc_pkg::*;

  srch_state_t        state, state_next;
  logic [COUNT_W-1:0] lo, lo_next;
  logic [COUNT_W-1:0] hi, hi_next;
  logic [COUNT_W-1:0] mid;
  logic               below;

  // Probe address and comparison against the entry read back.
  always_comb begin
    mid     = lo + ((hi - lo) >> 1);
    rd_addr = mid[ADDR_W-1:0];
    below   = req.strict ? (rd_data < req.key) : (rd_data <= req.key);
  end

  // Bounds and state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SR_IDLE;
    end else begin
      state <= state_next;
    end
    lo <= lo_next;
    hi <= hi_next;
  end

  // Next bounds; the rank is ready once the window has closed.
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    rsp.done   = 1'b0;
    rsp.rank   = lo;
    case (state)
      SR_IDLE: begin
        if (req.start) begin
          lo_next    = '0;
          hi_next    = req.total;
          state_next = SR_ADDR;
        end
      end
      SR_ADDR: begin
        if (lo < hi) begin
          state_next = SR_CMP;
        end else begin
          rsp.done   = 1'b1;
          state_next = SR_IDLE;
        end
      end
      SR_CMP: begin
        if (below) begin
          lo_next = mid + COUNT_W'(1);
        end else begin
          hi_next = mid;
        end
        state_next = SR_ADDR;
      end
      default: begin
        state_next = SR_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/interval_stabbing_counter.sv
// Top level of the interval stabbing counter: sequencer, two sorted stores and a search unit.
//
//   Channel  Dir  Payload                                   Accepted when
//   req      in   func, seg_start, seg_end, point_value     req.valid && req.ready
//   rsp      out  hit_count, status                         rsp.valid && rsp.ready
//
// One item is worked on at a time; req.ready is high only while the sequencer is idle.
// A clear, a rejected add or an unused func goes from idle through the done state to its result register.
// A query runs two binary searches through the one search unit, each probe passing an
// address state and a compare state.
// An add runs a search and a shift per store; the shift moves one entry a cycle through
// the RAM read port and then places the key.
// Reset clears the segment count and the control state; the stores need no clearing.
// A result waits in its own register, so a stalled rsp does not stop the next item being taken.
`timescale 1ns / 1ps

module interval_stabbing_counter (
  input  logic clk,
  input  logic rst,
  isc_in_if.sink    req,
  isc_out_if.source rsp
);
  import isc_pkg::*;

  ctl_state_t              state, state_next;
  logic [COUNT_W-1:0]      total, total_next;
  logic signed [KEY_W-1:0] key, key_next;
  logic signed [KEY_W-1:0] end_key, end_key_next;
  logic                    strict, strict_next;
  logic                    sel_end, sel_end_next;
  logic                    go, go_next;
  logic [COUNT_W-1:0]      pos, pos_next;
  logic [COUNT_W-1:0]      idx, idx_next;
  logic                    pend, pend_next;
  logic [ADDR_W-1:0]       waddr, waddr_next;
  logic [COUNT_W-1:0]      started, started_next;
  logic [COUNT_W-1:0]      res_hits, res_hits_next;
  status_t                 res_status, res_status_next;
  logic                    out_valid, out_valid_next;
  logic [COUNT_W-1:0]      out_hits, out_hits_next;
  status_t                 out_status, out_status_next;

  search_req_t             srch_req;
  search_rsp_t             srch_rsp;
  logic [ADDR_W-1:0]       srch_addr;

  logic                    we_start, we_end;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [KEY_W-1:0]        ram_wdata;
  logic [KEY_W-1:0]        start_rdata, end_rdata;
  logic signed [KEY_W-1:0] rd_sel;
  logic [COUNT_W-1:0]      idx_dec;

  // Sorted stores of start points and end points.
  isc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SEGMENTS)) u_start_ram (
    .clk   (clk),
    .we    (we_start),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (start_rdata)
  );

  isc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_SEGMENTS)) u_end_ram (
    .clk   (clk),
    .we    (we_end),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (end_rdata)
  );

  // Shared binary search unit.
  isc_search u_search (
    .clk     (clk),
    .rst     (rst),
    .req     (srch_req),
    .rd_data (rd_sel),
    .rd_addr (srch_addr),
    .rsp     (srch_rsp)
  );

  // Search request and read data of the store in use.
  always_comb begin
    rd_sel          = sel_end ? $signed(end_rdata) : $signed(start_rdata);
    srch_req.start  = go;
    srch_req.strict = strict;
    srch_req.total  = total;
    srch_req.key    = key;
    idx_dec         = idx - COUNT_W'(1);
  end

  // Result register on the output channel.
  assign rsp.valid     = out_valid;
  assign rsp.hit_count = HIT_W'(out_hits);
  assign rsp.status    = out_status;

  // State and data registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      total     <= '0;
      go        <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      total     <= total_next;
      go        <= go_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
    key        <= key_next;
    end_key    <= end_key_next;
    strict     <= strict_next;
    sel_end    <= sel_end_next;
    pos        <= pos_next;
    idx        <= idx_next;
    waddr      <= waddr_next;
    started    <= started_next;
    res_hits   <= res_hits_next;
    res_status <= res_status_next;
    out_hits   <= out_hits_next;
    out_status <= out_status_next;
  end

  // Sequencer: decode an item, run searches and shifts, then hand over the result.
  always_comb begin
    state_next      = state;
    total_next      = total;
    key_next        = key;
    end_key_next    = end_key;
    strict_next     = strict;
    sel_end_next    = sel_end;
    go_next         = 1'b0;
    pos_next        = pos;
    idx_next        = idx;
    pend_next       = pend;
    waddr_next      = waddr;
    started_next    = started;
    res_hits_next   = res_hits;
    res_status_next = res_status;
    out_valid_next  = out_valid && !rsp.ready;
    out_hits_next   = out_hits;
    out_status_next = out_status;
    req.ready       = 1'b0;
    we_start        = 1'b0;
    we_end          = 1'b0;
    ram_waddr       = waddr;
    ram_wdata       = rd_sel;
    ram_raddr       = srch_addr;

    case (state)
      T_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          res_hits_next   = '0;
          res_status_next = ST_OK;
          case (req.func)
            FN_CLEAR: begin
              total_next = '0;
              state_next = T_DONE;
            end
            FN_ADD: begin
              if (req.seg_start > req.seg_end) begin
                res_status_next = ST_ORDER;
                state_next      = T_DONE;
              end else if (total == COUNT_W'(MAX_SEGMENTS)) begin
                res_status_next = ST_FULL;
                state_next      = T_DONE;
              end else begin
                key_next     = req.seg_start;
                end_key_next = req.seg_end;
                strict_next  = 1'b0;
                sel_end_next = 1'b0;
                go_next      = 1'b1;
                state_next   = T_INS_SRCH;
              end
            end
            FN_QUERY: begin
              key_next     = req.point_value;
              strict_next  = 1'b0;
              sel_end_next = 1'b0;
              go_next      = 1'b1;
              state_next   = T_Q_START;
            end
            default: begin
              state_next = T_DONE;
            end
          endcase
        end
      end

      // Find the insertion point, after any equal keys.
      T_INS_SRCH: begin
        if (srch_rsp.done) begin
          pos_next   = srch_rsp.rank;
          idx_next   = total;
          pend_next  = 1'b0;
          state_next = T_SHIFT;
        end
      end

      // Move entries up by one, one read and one write a cycle, then place the key.
      T_SHIFT: begin
        if (pend) begin
          we_start = !sel_end;
          we_end   = sel_end;
        end
        if (idx > pos) begin
          ram_raddr  = idx_dec[ADDR_W-1:0];
          pend_next  = 1'b1;
          waddr_next = idx[ADDR_W-1:0];
          idx_next   = idx_dec;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            we_start  = !sel_end;
            we_end    = sel_end;
            ram_waddr = pos[ADDR_W-1:0];
            ram_wdata = key;
            if (!sel_end) begin
              sel_end_next = 1'b1;
              key_next     = end_key;
              go_next      = 1'b1;
              state_next   = T_INS_SRCH;
            end else begin
              total_next = total + COUNT_W'(1);
              state_next = T_DONE;
            end
          end
        end
      end

      // Count of starts at or below the point.
      T_Q_START: begin
        if (srch_rsp.done) begin
          started_next = srch_rsp.rank;
          sel_end_next = 1'b1;
          strict_next  = 1'b1;
          go_next      = 1'b1;
          state_next   = T_Q_END;
        end
      end

      // Count of ends below the point; the difference is the hit count.
      T_Q_END: begin
        if (srch_rsp.done) begin
          res_hits_next = (started >= srch_rsp.rank) ? (started - srch_rsp.rank) : '0;
          state_next    = T_DONE;
        end
      end

      // Load the result register once it is free.
      T_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_hits_next   = res_hits;
          out_status_next = res_status;
          state_next      = T_IDLE;
        end
      end

      default: begin
        state_next = T_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/isc_checker.sv
// Port-level assertions for the interval stabbing counter and the bind that attaches them.
`timescale 1ns / 1ps

module isc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [isc_pkg::HIT_W-1:0]     hit_count,
  input logic [isc_pkg::STATUS_W-1:0]  status
);
  import isc_pkg::*;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_count) && $stable(status))
    else $error("result changed while stalled");

  // One item at a time: the block is busy in the cycle after it takes an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while the previous one is still in work");

  // A rejected or dropped add carries no hits.
  a_reject_no_hits: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_ORDER) |-> hit_count == '0)
    else $error("hit count on a rejected add");

  // The hit count never exceeds the store size.
  a_hits_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hit_count <= HIT_W'(MAX_SEGMENTS))
    else $error("hit count above the store size");

  // No result is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind interval_stabbing_counter isc_checker u_isc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .hit_count (rsp.hit_count),
  .status    (rsp.status)
);

// File: tb/tb_interval_stabbing_counter.sv
// Self-checking testbench for the interval stabbing counter.
`timescale 1ns / 1ps

module tb_interval_stabbing_counter;
  import isc_pkg::*;

  // The func value with no operation behind it.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_ITEMS   = 320;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int NUM_ROWS       = 25;

  // One row of the directed stimulus; hit and st count only where fixed is set.
  typedef struct packed {
    logic [FUNC_W-1:0]       fn;
    logic signed [KEY_W-1:0] seg_lo;
    logic signed [KEY_W-1:0] seg_hi;
    logic signed [KEY_W-1:0] point;
    logic                    fixed;
    logic [HIT_W-1:0]        hit;
    status_t                 st;
  } stim_row_t;

  typedef struct {
    logic [HIT_W-1:0] hit;
    status_t          st;
  } hit_result_t;

  localparam stim_row_t STIM_TBL [NUM_ROWS] = '{
    '{FN_QUERY,  32'sd0,    32'sd0,    32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    KEY_MIN,   1'b1, 11'd0, ST_OK},
    '{FN_UNUSED, 32'sd0,    32'sd0,    32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_ADD,    KEY_MIN,   KEY_MAX,   32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_ADD,    32'sd5,    32'sd4,    32'sd0,    1'b1, 11'd0, ST_ORDER},
    '{FN_ADD,    KEY_MAX,   KEY_MIN,   32'sd0,    1'b1, 11'd0, ST_ORDER},
    '{FN_QUERY,  32'sd0,    32'sd0,    KEY_MIN,   1'b0, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    KEY_MAX,   1'b0, 11'd0, ST_OK},
    '{FN_ADD,    32'sd10,   32'sd10,   32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_ADD,    32'sd10,   32'sd20,   32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_ADD,    32'sd10,   32'sd20,   32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    32'sd10,   1'b0, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    32'sd20,   1'b0, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    32'sd21,   1'b0, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    32'sd9,    1'b0, 11'd0, ST_OK},
    '{FN_ADD,    -32'sd5,   32'sd10,   32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    -32'sd5,   1'b0, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    -32'sd6,   1'b0, 11'd0, ST_OK},
    '{FN_ADD,    KEY_MAX,   KEY_MAX,   32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    KEY_MAX,   1'b0, 11'd0, ST_OK},
    '{FN_UNUSED, -32'sd1,   -32'sd1,   -32'sd1,   1'b1, 11'd0, ST_OK},
    '{FN_CLEAR,  -32'sd1,   32'sd0,    -32'sd1,   1'b1, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    32'sd10,   1'b1, 11'd0, ST_OK},
    '{FN_ADD,    KEY_MIN,   KEY_MIN,   32'sd0,    1'b1, 11'd0, ST_OK},
    '{FN_QUERY,  32'sd0,    32'sd0,    KEY_MIN,   1'b0, 11'd0, ST_OK}
  };

  logic clk;
  logic rst;
  logic rx_ready = 1'b0;
  bit   no_idle = 1'b0;
  int   hold_asks = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  int   mismatch_count = 0;

  // Sorted start and end points of the segments held, and the results still owed.
  int          sorted_starts[$];
  int          sorted_ends[$];
  hit_result_t pending_results[$];

  isc_in_if  req_if();
  isc_out_if rsp_if();

  assign rsp_if.ready = rx_ready;

  interval_stabbing_counter DUT (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Number of stored keys at or below the key, or strictly below it.
  function automatic int count_keys(ref int keys[$], input int key, input bit strict);
    int n;
    n = 0;
    foreach (keys[i]) begin
      if (strict ? (keys[i] < key) : (keys[i] <= key)) n++;
    end
    return n;
  endfunction

  // A new key goes after any equal keys already held.
  function automatic void insert_sorted(ref int keys[$], input int key);
    int pos;
    pos = count_keys(keys, key, 1'b0);
    keys.insert(pos, key);
  endfunction

  // Works out the result of one item and updates the segment set.
  function automatic void stab_predict(input logic [FUNC_W-1:0] fn, input int lo, input int hi,
                                       input int pt, output logic [HIT_W-1:0] hits,
                                       output status_t st);
    int started;
    int ended;
    hits = '0;
    st   = ST_OK;
    case (fn)
      FN_CLEAR: begin
        sorted_starts.delete();
        sorted_ends.delete();
      end
      FN_ADD: begin
        if (lo > hi) begin
          st = ST_ORDER;
        end else if (sorted_starts.size() >= MAX_SEGMENTS) begin
          st = ST_FULL;
        end else begin
          insert_sorted(sorted_starts, lo);
          insert_sorted(sorted_ends, hi);
        end
      end
      FN_QUERY: begin
        started = count_keys(sorted_starts, pt, 1'b0);
        ended   = count_keys(sorted_ends, pt, 1'b1);
        hits    = (started >= ended) ? HIT_W'(started - ended) : '0;
      end
      default: ;
    endcase
  endfunction

  // Mostly small keys so that segments overlap and share endpoints.
  function automatic int rand_key();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(100)) - 50;
      6: begin
        case ($urandom_range(3))
          0: return KEY_MIN;
          1: return KEY_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom);
    endcase
  endfunction

  // Query points fall on or next to stored endpoints half of the time while segments are held.
  function automatic int pick_point();
    int k;
    if (sorted_starts.size() == 0 || $urandom_range(1) == 0) return rand_key();
    k = $urandom_range(sorted_starts.size() - 1);
    return ($urandom_range(1) ? sorted_starts[k] : sorted_ends[k]) + int'($urandom_range(2)) - 1;
  endfunction

  // Offers one item and, once it is taken, files the result it must give.
  task automatic offer_item(input logic [FUNC_W-1:0] fn, input int lo, input int hi,
                            input int pt, input logic fixed, input logic [HIT_W-1:0] hit,
                            input status_t st);
    hit_result_t      want;
    logic [HIT_W-1:0] p_hit;
    status_t          p_st;
    while (!no_idle && $urandom_range(99) < 36) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.func        <= fn;
    req_if.seg_start   <= lo;
    req_if.seg_end     <= hi;
    req_if.point_value <= pt;
    do @(posedge clk); while (!req_if.ready);
    stab_predict(fn, lo, hi, pt, p_hit, p_st);
    want.hit = fixed ? hit : p_hit;
    want.st  = fixed ? st : p_st;
    pending_results.push_back(want);
  endtask

  task automatic wait_for_results;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result side: checks each result and drives ready, with one long hold-off on request.
  always @(posedge clk) begin
    hit_result_t want;
    if (rst) begin
      rx_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: hit_count %0d status %0d",
                   $time, rsp_if.hit_count, rsp_if.status);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.hit_count !== want.hit) begin
            $display("%0t: hit_count expected %0d got %0d", $time, want.hit, rsp_if.hit_count);
            mismatch_count++;
          end
          if (rsp_if.status !== want.st) begin
            $display("%0t: status expected %s got %0d", $time, want.st.name(), rsp_if.status);
            mismatch_count++;
          end
        end
      end
      if (hold_seen != hold_asks) begin
        hold_seen <= hold_asks;
        hold_left <= HOLD_CYCLES;
        rx_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rx_ready  <= 1'b0;
      end else begin
        rx_ready <= no_idle || ($urandom_range(99) >= 36);
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed rows, a full table, then random sessions of segments.
  initial begin
    logic [FUNC_W-1:0] fn;
    int lo;
    int hi;
    int pt;
    int r;
    int rand_done;
    int session_cap;

    rst                <= 1'b1;
    req_if.valid       <= 1'b0;
    req_if.func        <= FN_CLEAR;
    req_if.seg_start   <= '0;
    req_if.seg_end     <= '0;
    req_if.point_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      offer_item(STIM_TBL[i].fn, STIM_TBL[i].seg_lo, STIM_TBL[i].seg_hi, STIM_TBL[i].point,
                 STIM_TBL[i].fixed, STIM_TBL[i].hit, STIM_TBL[i].st);
    end

    // Fill the table. Keys rise so each insertion lands at the end and the shift stays short;
    // every segment covers zero.
    offer_item(FN_CLEAR, $urandom, $urandom, $urandom, 1'b1, '0, ST_OK);
    lo = -5000 - int'($urandom_range(100000));
    hi = int'($urandom_range(1000));
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      offer_item(FN_ADD, lo, hi, $urandom, 1'b1, '0, ST_OK);
      lo += int'($urandom_range(3));
      hi += int'($urandom_range(3));
    end
    offer_item(FN_QUERY, $urandom, $urandom, 0, 1'b1, HIT_W'(MAX_SEGMENTS), ST_OK);
    offer_item(FN_QUERY, $urandom, $urandom, KEY_MIN, 1'b0, '0, ST_OK);
    offer_item(FN_QUERY, $urandom, $urandom, KEY_MAX, 1'b0, '0, ST_OK);
    for (int i = 0; i < 8; i++) begin
      offer_item(FN_QUERY, $urandom, $urandom, int'($urandom_range(8000)) - 4000, 1'b0, '0,
                 ST_OK);
    end
    offer_item(FN_ADD, -7, 7, $urandom, 1'b1, '0, ST_FULL);
    offer_item(FN_ADD, 7, -7, $urandom, 1'b1, '0, ST_ORDER);
    offer_item(FN_CLEAR, $urandom, $urandom, $urandom, 1'b1, '0, ST_OK);

    // Random sessions: grow a small set, query it, clear it now and then.
    rand_done   = 0;
    session_cap = $urandom_range(48, 1);
    while (rand_done < RANDOM_ITEMS) begin
      lo = $urandom;
      hi = $urandom;
      pt = $urandom;
      r  = $urandom_range(99);
      if (sorted_starts.size() >= session_cap || r < 2) begin
        fn          = FN_CLEAR;
        session_cap = $urandom_range(48, 1);
      end else if (r < 5) begin
        fn = FN_UNUSED;
      end else if (r < 45) begin
        fn = FN_ADD;
        lo = rand_key();
        hi = ($urandom_range(9) == 0) ? lo : rand_key();
        // Most segments are well formed; the rest are rejected.
        if ($urandom_range(9) != 0 && lo > hi) begin
          pt = lo;
          lo = hi;
          hi = pt;
        end
      end else begin
        fn = FN_QUERY;
        pt = pick_point();
      end
      offer_item(fn, lo, hi, pt, 1'b0, '0, ST_OK);
      if (fn != FN_UNUSED) begin
        rand_done++;
        if (rand_done == 60) hold_asks++;
        no_idle = (rand_done >= 120 && rand_done < 220);
        if (rand_done == 260) begin
          req_if.valid <= 1'b0;
          wait_for_results();
        end
      end
    end

    req_if.valid <= 1'b0;
    wait_for_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
